/* sv/bsbh_pkg.sv */
// Shared types and constants of the byte-string bucket hash.
package bsbh_pkg;

   localparam int HASH_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int MAX_KEY_LEN = 64;
   localparam int DIV_STEPS   = HASH_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [LEN_W-1:0] MAX_LEN_VAL = LEN_W'(MAX_KEY_LEN);
   localparam logic [HASH_W-1:0] BUCKET_COUNT_RESET = HASH_W'(1024);

   typedef logic [HASH_W-1:0] word_type;

   // Operand pair issued to the shared multiplier.
   typedef struct packed {
      word_type a;
      word_type b;
   } mul_req_type;

   // Command to the remainder unit.
   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   // Status of the remainder unit.
   typedef struct packed {
      logic     busy;
      word_type remainder;
   } div_sts_type;

endpackage

/* sv/bsbh_ifs.sv */
// Valid/ready channel interfaces for key bytes and hash results.
interface bsbh_req_if import bsbh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] key_byte;
   logic [LEN_W-1:0]  key_length;

   modport source (output valid, output key_byte, output key_length, input ready);
   modport sink   (input valid, input key_byte, input key_length, output ready);
endinterface

interface bsbh_rsp_if import bsbh_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type bucket_index;
   word_type hash_value;

   modport source (output valid, output bucket_index, output hash_value, input ready);
   modport sink   (input valid, input bucket_index, input hash_value, output ready);
endinterface

/* sv/bsbh_mul.sv */
// Shared 32x32 multiplier keeping the low word, with a registered product.
module bsbh_mul
   import bsbh_pkg::*;
(
   input  logic        clock,
   input  mul_req_type mul_req,
   output word_type    prod_ff
);

   logic [2*HASH_W-1:0] full_prod;

   assign full_prod = {{HASH_W{1'b0}}, mul_req.a} * {{HASH_W{1'b0}}, mul_req.b};

   always_ff @(posedge clock) begin
      prod_ff <= full_prod[HASH_W-1:0];
   end

endmodule

/* sv/bsbh_div.sv */
// Restoring radix-2 remainder unit, one quotient bit per cycle.
module bsbh_div
   import bsbh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_sts_type div_sts
);

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   word_type             rem_ff;
   word_type             dividend_ff;
   word_type             divisor_ff;
   logic [HASH_W+1:0]    trial;

   // A zero divisor never borrows, so the remainder ends equal to the dividend.
   assign trial = {1'b0, rem_ff, dividend_ff[HASH_W-1]} - {2'b00, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (div_req.start) begin
         busy_ff  <= 1'b1;
         count_ff <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff      <= '0;
         dividend_ff <= div_req.dividend;
         divisor_ff  <= div_req.divisor;
      end else if (busy_ff) begin
         dividend_ff <= {dividend_ff[HASH_W-2:0], 1'b0};
         if (trial[HASH_W+1]) begin
            rem_ff <= {rem_ff[HASH_W-2:0], dividend_ff[HASH_W-1]};
         end else begin
            rem_ff <= trial[HASH_W-1:0];
         end
      end
   end

   assign div_sts.busy      = busy_ff;
   assign div_sts.remainder = rem_ff;

endmodule

/* sv/byte_string_bucket_hash.sv */
// Top level of the byte-string bucket hash: sequencer, state and ports.
//
// Keys arrive one byte per transfer on req, with the key length repeated on
// every byte. Bytes whose length is zero or above MAX_KEY_LEN are taken and
// dropped without touching the running state. A byte that does not end its
// key passes through the states MUL_A, UPDATE and END before the next byte
// can be taken (the third and later bytes also pass through MUL_B, as they
// need two dependent multiplies); all multiplies run one at a time through a
// single shared 32x32 multiplier with a registered product. The last byte of
// a key also multiplies the hash by the length and then computes the bucket
// index in a bit-serial remainder unit before the next byte is taken. The
// result sits in an output register on rsp, so the next key can start while
// a result waits; a second result waits in the remainder unit until the
// first one has been transferred. A bucket count of zero yields a bucket
// index equal to the hash value. The csr write port loads the bucket count
// (reset value 1024) and is meant to be used only while the block is idle.
module byte_string_bucket_hash
   import bsbh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   bsbh_req_if.sink         req,
   bsbh_rsp_if.source       rsp,
   input  logic             csr_wr_en,
   input  word_type         csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_UPDATE,
      ST_MUL_B,
      ST_END,
      ST_FINAL,
      ST_DIV
   } state_type;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   word_type          hash_ff, hash_in;
   word_type          final_ff, final_in;
   word_type          bucket_count_ff, bucket_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   word_type          rsp_index_ff, rsp_index_in;
   word_type          rsp_hash_ff, rsp_hash_in;

   mul_req_type mul_req;
   word_type    prod;
   div_req_type div_req;
   div_sts_type div_sts;

   logic             req_accept;
   logic             len_ok;
   logic [LEN_W:0]   next_pos;
   word_type         factor;

   bsbh_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod)
   );

   bsbh_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign len_ok     = (req.key_length != '0) && (req.key_length <= MAX_LEN_VAL);
   assign next_pos   = {1'b0, pos_ff} + 1'b1;

   // Per-byte factor for the third and later bytes: byte*pos + length + pos.
   assign factor = prod + HASH_W'(len_ff) + HASH_W'(pos_ff);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.bucket_index = rsp_index_ff;
   assign rsp.hash_value   = rsp_hash_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_req.a = HASH_W'(byte_ff);
      mul_req.b = HASH_W'(pos_ff);
      unique case (state_ff)
         ST_MUL_A: begin
            if (pos_ff == LEN_W'(1)) begin
               mul_req.b = HASH_W'(len_ff);
            end
         end
         ST_UPDATE: begin
            mul_req.a = hash_ff;
            mul_req.b = factor;
         end
         ST_END: begin
            mul_req.a = hash_ff;
            mul_req.b = HASH_W'(len_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      byte_in         = byte_ff;
      len_in          = len_ff;
      pos_in          = pos_ff;
      hash_in         = hash_ff;
      final_in        = final_ff;
      bucket_count_in = csr_wr_en ? csr_wr_data : bucket_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_index_in    = rsp_index_ff;
      rsp_hash_in     = rsp_hash_ff;

      div_req.start    = 1'b0;
      div_req.dividend = prod;
      div_req.divisor  = bucket_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && len_ok) begin
               byte_in  = req.key_byte;
               len_in   = req.key_length;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // The first byte seeds the hash; the second adds byte*length.
            if (pos_ff == '0) begin
               hash_in  = HASH_W'(byte_ff);
               state_in = ST_END;
            end else if (pos_ff == LEN_W'(1)) begin
               hash_in  = hash_ff + prod;
               state_in = ST_END;
            end else begin
               state_in = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            hash_in  = prod;
            state_in = ST_END;
         end
         ST_END: begin
            if (next_pos < {1'b0, len_ff}) begin
               pos_in   = next_pos[LEN_W-1:0];
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            // Product now holds hash*length; start the remainder and clear
            // the running state for the next key.
            final_in      = prod;
            div_req.start = 1'b1;
            hash_in       = '0;
            pos_in        = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (!div_sts.busy && (!rsp_valid_ff || rsp.ready)) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = div_sts.remainder;
               rsp_hash_in  = final_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pos_ff          <= '0;
         hash_ff         <= '0;
         bucket_count_ff <= BUCKET_COUNT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         hash_ff         <= hash_in;
         bucket_count_ff <= bucket_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      byte_ff      <= byte_in;
      len_ff       <= len_in;
      final_ff     <= final_in;
      rsp_index_ff <= rsp_index_in;
      rsp_hash_ff  <= rsp_hash_in;
   end

endmodule

/* sv/bsbh_checker.sv */
// Port-level checks of the byte-string bucket hash, bound to the top level.
module bsbh_checker
   import bsbh_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [LEN_W-1:0]  req_key_length,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input word_type          rsp_bucket_index,
   input word_type          rsp_hash_value
);

   logic req_take;

   assign req_take = req_valid && req_ready && (req_key_length != '0)
                     && (req_key_length <= MAX_LEN_VAL);

   // A result stays offered until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_bucket_index) && $stable(rsp_hash_value))
      else $error("result payload changed while stalled");

   // A byte of legal length starts work, so the next byte is not taken at once.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("byte taken while previous byte still in work");

   // No result right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind byte_string_bucket_hash bsbh_checker u_bsbh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_key_length   (req.key_length),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_bucket_index (rsp.bucket_index),
   .rsp_hash_value   (rsp.hash_value)
);
